/* hdl/csv_field_tokenizer_assert.svh */
// Assertion macros shared by the checker of the CSV field tokenizer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cft assertion failed");

// Next-cycle implication, disabled during reset
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cft assertion failed");

`endif

/* hdl/cft_pkg.sv */
// Package of the CSV field tokenizer: result kinds, field modes,
// byte codes, register indexes and the escape translation. No dependencies.
package cft_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_UNKNOWN  = 2'd0,
        MODE_QUOTED   = 2'd1,
        MODE_UNQUOTED = 2'd2
    } t_mode;

    // Register indexes of the configuration port
    localparam logic CFG_FIELD_SEPARATOR = 1'b0;
    localparam logic CFG_MAX_LINE_LENGTH = 1'b1;

    localparam logic [7:0]  FIELD_SEPARATOR_RESET = 8'd44;
    localparam logic [15:0] MAX_LINE_LENGTH_RESET = 16'd512;

    // Byte codes
    localparam logic [7:0] QUOTE_BYTE     = 8'h22;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] CR_BYTE        = 8'h0D;
    localparam logic [7:0] LF_BYTE        = 8'h0A;
    localparam logic [7:0] TAB_BYTE       = 8'h09;
    localparam logic [7:0] ESC_N_BYTE     = 8'h6E;
    localparam logic [7:0] ESC_R_BYTE     = 8'h72;
    localparam logic [7:0] ESC_T_BYTE     = 8'h74;

    // Byte that follows a backslash: \n, \r, \t translate, others pass
    function automatic logic [7:0] cft_unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            ESC_N_BYTE: r = LF_BYTE;
            ESC_R_BYTE: r = CR_BYTE;
            ESC_T_BYTE: r = TAB_BYTE;
            default:    r = c;
        endcase
        return r;
    endfunction

endpackage

/* hdl/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer: row state, configuration
// registers and the result register. Depends on cft_pkg.

// The tokenizer takes one raw CSV byte per cycle and answers with at most one
// result, registered in the cycle after the byte is taken: an unescaped data
// byte, a field end, a row end, or a row-too-long error. Sustained rate is one
// byte per clock; the only thing that holds the input back is the single
// result register while the downstream side stalls it (o_stall follows i_stall
// when a result is waiting). Bytes that produce no result (CR outside quotes,
// opening and closing quotes, backslashes) are still taken. The user must
// write the field separator and row length limit through the configuration
// port while the block is idle; this is not enforced. The port is always ready.
module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int LINE_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_result_kind,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CMP_W = (LINE_COUNT_BITS > 16) ? LINE_COUNT_BITS : 16;

    // configuration registers
    logic [7:0]  r_field_sep;
    logic [15:0] r_max_len;

    // row state
    t_mode                      r_mode, n_mode;
    logic                       r_in_quotes, n_in_quotes;
    logic                       r_escape, n_escape;
    logic [7:0]                 r_prev, n_prev;
    logic                       r_row_nonempty, n_row_nonempty;
    logic [LINE_COUNT_BITS-1:0] r_raw_count, n_raw_count;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    t_kind       r_out_kind;

    logic        w_accept;
    logic        w_has_result;
    logic [7:0]  w_res_byte;
    t_kind       w_res_kind;
    logic [LINE_COUNT_BITS-1:0] w_raw_inc;
    logic        w_too_long;
    t_mode       w_mode_eff;
    logic [7:0]  c;

    assign o_stall     = r_out_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_result_kind = r_out_kind;

    // saturating raw byte count and limit check
    assign w_raw_inc  = (&r_raw_count) ? r_raw_count
                                       : r_raw_count + LINE_COUNT_BITS'(1);
    assign w_too_long = CMP_W'(w_raw_inc) > CMP_W'(r_max_len);
    assign w_mode_eff = (r_mode == MODE_UNKNOWN) ? MODE_UNQUOTED : r_mode;
    assign c          = i_in_byte;

    // per-byte state update and result
    always_comb begin
        n_mode         = r_mode;
        n_in_quotes    = r_in_quotes;
        n_escape       = r_escape;
        n_prev         = r_prev;
        n_row_nonempty = r_row_nonempty;
        n_raw_count    = r_raw_count;
        w_has_result   = 1'b0;
        w_res_byte     = 8'd0;
        w_res_kind     = KIND_DATA;

        if (i_end_of_input) begin
            // flush: row end only when something was written
            n_mode         = MODE_UNKNOWN;
            n_in_quotes    = 1'b0;
            n_escape       = 1'b0;
            n_prev         = 8'd0;
            n_row_nonempty = 1'b0;
            n_raw_count    = '0;
            w_has_result   = r_row_nonempty;
            w_res_kind     = KIND_ROW;
        end else if (w_too_long) begin
            n_mode         = MODE_UNKNOWN;
            n_in_quotes    = 1'b0;
            n_escape       = 1'b0;
            n_prev         = 8'd0;
            n_row_nonempty = 1'b0;
            n_raw_count    = '0;
            w_has_result   = 1'b1;
            w_res_kind     = KIND_ERROR;
        end else begin
            n_raw_count = w_raw_inc;
            if (r_escape) begin
                n_escape       = 1'b0;
                w_has_result   = 1'b1;
                w_res_byte     = cft_unescape(c);
                n_prev         = w_res_byte;
                n_row_nonempty = 1'b1;
            end else if (r_mode == MODE_UNKNOWN && c == QUOTE_BYTE) begin
                // opening quote of a quoted field
                n_mode      = MODE_QUOTED;
                n_in_quotes = 1'b1;
                n_prev      = 8'd0;
            end else begin
                n_mode = w_mode_eff;
                if (c == QUOTE_BYTE) begin
                    n_in_quotes = !r_in_quotes;
                    if (w_mode_eff == MODE_QUOTED) begin
                        if (r_prev == QUOTE_BYTE) begin
                            // doubled quote gives one quote
                            w_has_result   = 1'b1;
                            w_res_byte     = QUOTE_BYTE;
                            n_prev         = 8'd0;
                            n_row_nonempty = 1'b1;
                        end else begin
                            n_prev = QUOTE_BYTE;
                        end
                    end else begin
                        w_has_result   = 1'b1;
                        w_res_byte     = c;
                        n_prev         = c;
                        n_row_nonempty = 1'b1;
                    end
                end else if (c == BACKSLASH_BYTE) begin
                    n_escape = 1'b1;
                end else if (!r_in_quotes && c == r_field_sep) begin
                    n_mode         = MODE_UNKNOWN;
                    w_has_result   = 1'b1;
                    w_res_kind     = KIND_FIELD;
                    n_prev         = 8'd0;
                    n_row_nonempty = 1'b1;
                end else if (!r_in_quotes && c == CR_BYTE) begin
                    // dropped
                end else if (!r_in_quotes && c == LF_BYTE) begin
                    n_mode         = MODE_UNKNOWN;
                    n_in_quotes    = 1'b0;
                    n_escape       = 1'b0;
                    n_prev         = 8'd0;
                    n_row_nonempty = 1'b0;
                    n_raw_count    = '0;
                    w_has_result   = 1'b1;
                    w_res_kind     = KIND_ROW;
                end else begin
                    w_has_result   = 1'b1;
                    w_res_byte     = c;
                    n_prev         = c;
                    n_row_nonempty = 1'b1;
                end
            end
        end
    end

    // row state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_UNKNOWN;
            r_in_quotes    <= 1'b0;
            r_escape       <= 1'b0;
            r_prev         <= 8'd0;
            r_row_nonempty <= 1'b0;
            r_raw_count    <= '0;
        end else if (w_accept) begin
            r_mode         <= n_mode;
            r_in_quotes    <= n_in_quotes;
            r_escape       <= n_escape;
            r_prev         <= n_prev;
            r_row_nonempty <= n_row_nonempty;
            r_raw_count    <= n_raw_count;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_sep <= FIELD_SEPARATOR_RESET;
            r_max_len   <= MAX_LINE_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIELD_SEPARATOR: r_field_sep <= i_cfg_data[7:0];
                CFG_MAX_LINE_LENGTH: r_max_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register: valid is control, payload loads on a new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_has_result;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_has_result) begin
            r_out_byte <= w_res_byte;
            r_out_kind <= w_res_kind;
        end
    end

endmodule

/* hdl/cft_checker.sv */
// Port-level checker of the CSV field tokenizer, bound to the top level.
// Depends on cft_pkg and csv_field_tokenizer_assert.svh.
`include "csv_field_tokenizer_assert.svh"

module cft_checker
    import cft_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_end_of_input,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_result_kind
);

    logic       w_eoi_accept;
    logic       w_held;
    logic       w_mark;
    logic [9:0] w_out_payload;

    assign w_eoi_accept  = i_valid && !o_stall && i_end_of_input;
    assign w_held        = o_valid && i_stall;
    assign w_mark        = o_valid && (o_result_kind != KIND_DATA);
    assign w_out_payload = {o_out_byte, o_result_kind};

    // a waiting result holds while stalled
    `CFT_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_held, o_valid && $stable(w_out_payload))

    // marks carry a zero byte
    `CFT_ASSERT_NOW(a_mark_byte_zero, i_clk, i_rst_n, w_mark, o_out_byte == 8'd0)

    // with the result register empty the input never stalls
    `CFT_ASSERT_NOW(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall)

    // a second end of input right after the first finds an empty row
    `CFT_ASSERT_NEXT(a_double_eoi_silent, i_clk, i_rst_n, $past(w_eoi_accept) && w_eoi_accept, !o_valid)

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);

/* bench/csv_field_tokenizer_tb.sv */
// Self-checking bench for csv_field_tokenizer: a queued byte driver, a result
// monitor and a tokenizer predictor that runs alongside the block.
// Depends on cft_pkg and csv_field_tokenizer.
`timescale 1ns / 100ps

module csv_field_tokenizer_tb;
    import cft_pkg::*;

    localparam int CNT_BITS       = 16;
    localparam int PHASE_ITEMS    = 52;
    localparam int SETTING_COUNT  = 9;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } t_raw_item;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_result_kind;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_FIELD_SEPARATOR;
    logic [15:0] i_cfg_data = 16'h0000;

    // Pending raw bytes and expected tokens
    t_raw_item raw_q[$];
    t_token    token_q[$];

    // Predictor copy of the registers and the row state
    logic [7:0]          sep_cfg = FIELD_SEPARATOR_RESET;
    logic [15:0]         len_cfg = MAX_LINE_LENGTH_RESET;
    t_mode               mode_r = MODE_UNKNOWN;
    logic                quoted_r = 1'b0;
    logic                esc_r = 1'b0;
    logic [7:0]          last_r = 8'h00;
    logic [CNT_BITS-1:0] written_r = '0;
    logic [CNT_BITS-1:0] raw_r = '0;

    int   fails = 0;
    int   bytes_taken = 0;
    int   tokens_checked = 0;
    int   settings_done = 1;
    int   queued_in_phase = 0;
    int   kind_seen[4] = '{0, 0, 0, 0};
    logic calm = 1'b0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   hold_next;
    int   idle_cycles = 0;
    t_raw_item nxt;
    t_token    exp_tok;

    csv_field_tokenizer #(
        .LINE_COUNT_BITS(CNT_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_result_kind  (o_result_kind),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wait drawn per transaction; calm phases run back to back
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic push_item(input logic [7:0] b, input logic e);
        raw_q.push_back('{b: b, eoi: e});
        queued_in_phase++;
    endtask

    // ------------------------------------------------------------------
    // Tokenizer predictor
    // ------------------------------------------------------------------
    task automatic clear_row();
        mode_r    = MODE_UNKNOWN;
        quoted_r  = 1'b0;
        esc_r     = 1'b0;
        last_r    = 8'h00;
        written_r = '0;
        raw_r     = '0;
    endtask

    // Queue a token; data bytes and field ends count toward the row
    task automatic emit_token(input logic [7:0] b, input t_kind k);
        token_q.push_back('{data: b, kind: k});
        if (k == KIND_DATA || k == KIND_FIELD) begin
            if (written_r != '1)
                written_r++;
            last_r = b;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] b_in, input logic eoi);
        logic [7:0] c;
        logic       nonempty;
        c = b_in;
        if (eoi) begin
            // flush a non-empty row; a pending escape is dropped
            nonempty = (written_r != 0);
            clear_row();
            if (nonempty)
                emit_token(8'h00, KIND_ROW);
        end else begin
            if (raw_r != '1)
                raw_r++;
            if (raw_r > len_cfg) begin
                clear_row();
                emit_token(8'h00, KIND_ERROR);
            end else if (esc_r) begin
                esc_r = 1'b0;
                case (c)
                    ESC_N_BYTE: c = LF_BYTE;
                    ESC_R_BYTE: c = CR_BYTE;
                    ESC_T_BYTE: c = TAB_BYTE;
                    default:    c = c;
                endcase
                emit_token(c, KIND_DATA);
            end else if (mode_r == MODE_UNKNOWN && c == QUOTE_BYTE) begin
                // opening quote of a quoted field
                mode_r   = MODE_QUOTED;
                quoted_r = 1'b1;
                last_r   = 8'h00;
            end else begin
                if (mode_r == MODE_UNKNOWN)
                    mode_r = MODE_UNQUOTED;
                if (c == QUOTE_BYTE) begin
                    quoted_r = !quoted_r;
                    if (mode_r == MODE_QUOTED) begin
                        // doubled quote gives one quote byte
                        if (last_r == QUOTE_BYTE) begin
                            emit_token(QUOTE_BYTE, KIND_DATA);
                            last_r = 8'h00;
                        end else begin
                            last_r = QUOTE_BYTE;
                        end
                    end else begin
                        emit_token(c, KIND_DATA);
                    end
                end else if (c == BACKSLASH_BYTE) begin
                    esc_r = 1'b1;
                end else if (!quoted_r && c == sep_cfg) begin
                    mode_r = MODE_UNKNOWN;
                    emit_token(8'h00, KIND_FIELD);
                end else if (!quoted_r && c == CR_BYTE) begin
                    // bare CR dropped
                end else if (!quoted_r && c == LF_BYTE) begin
                    clear_row();
                    emit_token(8'h00, KIND_ROW);
                end else begin
                    emit_token(c, KIND_DATA);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Byte driver: predicts on every accepted transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                tokenize_byte(i_in_byte, i_end_of_input);
                bytes_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (raw_q.size() != 0) begin
                    nxt = raw_q.pop_front();
                    i_valid        <= 1'b1;
                    i_in_byte      <= nxt.b;
                    i_end_of_input <= nxt.eoi;
                    gap_left       <= draw_wait();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else begin
            hold_next = hold_left;
            if (o_valid && !i_stall) begin
                hold_next = draw_wait();
                if (token_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got kind %0d byte %h",
                             $time, o_result_kind, o_out_byte);
                end else begin
                    exp_tok = token_q.pop_front();
                    tokens_checked++;
                    kind_seen[exp_tok.kind]++;
                    if (o_result_kind !== exp_tok.kind) begin
                        fails++;
                        $display("%0t: result kind mismatch, expected %0d, got %0d",
                                 $time, exp_tok.kind, o_result_kind);
                    end
                    if (o_out_byte !== exp_tok.data) begin
                        fails++;
                        $display("%0t: out byte mismatch, expected %h, got %h",
                                 $time, exp_tok.data, o_out_byte);
                    end
                end
            end
            if (hold_next != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_next - 1;
            end else begin
                i_stall   <= 1'b0;
                hold_left <= 0;
            end
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, token_q.size());
                $display("** csv_field_tokenizer: FAILED **");
                $finish;
            end
        end
    end

    // Register write on the configuration channel
    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FIELD_SEPARATOR)
            sep_cfg = data[7:0];
        else
            len_cfg = data;
    endtask

    // All bytes taken and all tokens seen, then a short latency pause
    task automatic wait_idle();
        do @(posedge i_clk);
        while (raw_q.size() != 0 || i_valid || token_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One CSV row of random content with the current separator
    task automatic queue_row();
        int   nf;
        int   nb;
        logic qf;
        nf = $urandom_range(1, 4);
        for (int k = 0; k < nf; k++) begin
            qf = ($urandom_range(0, 2) == 0);
            if (qf)
                push_item(QUOTE_BYTE, 1'b0);
            nb = $urandom_range(0, 6);
            for (int j = 0; j < nb; j++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        push_item(BACKSLASH_BYTE, 1'b0);
                        case ($urandom_range(0, 3))
                            0:       push_item(ESC_N_BYTE, 1'b0);
                            1:       push_item(ESC_R_BYTE, 1'b0);
                            2:       push_item(ESC_T_BYTE, 1'b0);
                            default: push_item(8'($urandom_range(0, 255)), 1'b0);
                        endcase
                    end
                    1: begin
                        push_item(QUOTE_BYTE, 1'b0);
                        if (qf)
                            push_item(QUOTE_BYTE, 1'b0);
                    end
                    2: push_item(8'($urandom_range(0, 255)), 1'b0);
                    3: begin
                        // embedded separator / line break inside quotes, CR outside
                        if (qf)
                            push_item($urandom_range(0, 1) ? sep_cfg : LF_BYTE, 1'b0);
                        else
                            push_item(CR_BYTE, 1'b0);
                    end
                    default: push_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
                endcase
            end
            if (qf)
                push_item(QUOTE_BYTE, 1'b0);
            if (k != nf - 1)
                push_item(sep_cfg, 1'b0);
        end
        case ($urandom_range(0, 5))
            0: begin
                push_item(CR_BYTE, 1'b0);
                push_item(LF_BYTE, 1'b0);
            end
            1:       push_item(8'($urandom_range(0, 255)), 1'b1);
            default: push_item(LF_BYTE, 1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        string      txt;
        logic [7:0] sep_new;
        logic [7:0] upper;
        logic [15:0] len_new;

        // Directed: quoted field with doubled quote, all escapes, CR LF,
        // quote inside an unquoted field, extreme bytes, escape at end of
        // input, then end of input on an empty row
        txt = "a,\"b\"\"c\",\\n\\t\\r\\x";
        for (int i = 0; i < txt.len(); i++)
            push_item(txt[i], 1'b0);
        push_item(CR_BYTE, 1'b0);
        push_item(LF_BYTE, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(QUOTE_BYTE, 1'b0);
        push_item(8'h2C, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(BACKSLASH_BYTE, 1'b0);
        push_item(8'hA5, 1'b1);
        push_item(8'h5A, 1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random rows under a series of separator / length settings
        for (int p = 0; p < SETTING_COUNT; p++) begin
            wait_idle();
            case (p)
                0: begin sep_new = 8'h00;          len_new = 16'd1;     end
                1: begin sep_new = 8'hFF;          len_new = 16'd65535; end
                2: begin sep_new = 8'h3B;          len_new = 16'd8;     end
                3: begin sep_new = QUOTE_BYTE;     len_new = 16'd20;    end
                4: begin sep_new = CR_BYTE;        len_new = 16'd30;    end
                5: begin sep_new = LF_BYTE;        len_new = 16'd16;    end
                6: begin sep_new = BACKSLASH_BYTE; len_new = 16'd2;     end
                7: begin
                    sep_new = 8'($urandom_range(0, 255));
                    len_new = 16'($urandom_range(3, 40));
                end
                default: begin sep_new = 8'h2C;    len_new = 16'd512;   end
            endcase
            upper = 8'($urandom_range(0, 255));
            write_reg(CFG_FIELD_SEPARATOR, {upper, sep_new});
            write_reg(CFG_MAX_LINE_LENGTH, len_new);
            settings_done++;
            calm = ($urandom_range(0, 3) == 0);
            queued_in_phase = 0;
            while (queued_in_phase < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0:       push_item(8'($urandom_range(0, 255)), 1'b0);
                    1:       push_item(8'($urandom_range(0, 255)), 1'b1);
                    default: queue_row();
                endcase
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Streamed %0d bytes under %0d separator/length settings, %0d results checked:",
                 bytes_taken, settings_done, tokens_checked);
        $display("  %0d data bytes, %0d field ends, %0d row ends, %0d overlong rows",
                 kind_seen[KIND_DATA], kind_seen[KIND_FIELD], kind_seen[KIND_ROW],
                 kind_seen[KIND_ERROR]);
        if (fails == 0 && token_q.size() == 0) begin
            $display("** csv_field_tokenizer: PASSED **");
        end else begin
            $display("** csv_field_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/cft_pkg.sv
hdl/csv_field_tokenizer.sv
hdl/cft_checker.sv
bench/csv_field_tokenizer_tb.sv
